// ===== src/pecs_pkg.sv =====
// Package for the puck collision stepper: record, command and status types,
// register indexes and field widths. No dependencies.
package pecs_pkg;

  localparam int MAX_PUCKS_DEF = 8;
  localparam int POS_W  = 20;
  localparam int VEL_W  = 16;
  localparam int RAD_W  = 7;
  localparam int MASS_W = 8;
  localparam int FLD_W  = 10;
  localparam int ACT_W  = 4;
  localparam int DIV_STEPS = 20;

  localparam logic [1:0] REG_FIELD_W = 2'd0;
  localparam logic [1:0] REG_FIELD_H = 2'd1;
  localparam logic [1:0] REG_ACTIVE  = 2'd2;

  localparam logic [FLD_W-1:0] FIELD_W_RST = 10'd320;
  localparam logic [FLD_W-1:0] FIELD_H_RST = 10'd240;
  localparam logic [ACT_W-1:0] ACTIVE_RST  = 4'd5;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [VEL_W-1:0]  vx;
    logic [VEL_W-1:0]  vy;
    logic [RAD_W-1:0]  rad;
    logic [MASS_W-1:0] mass;
  } puck_t;

  localparam int PUCK_W = $bits(puck_t);
  localparam puck_t PUCK_RST = '{x: '0, y: '0, vx: '0, vy: '0, rad: 7'd1, mass: 8'd16};

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_CAP_A, DP_CAP_B, DP_DIFF, DP_SQX, DP_SQY, DP_SQR,
    DP_DOTX, DP_DOTY, DP_DOTS, DP_DEN, DP_NUM1, DP_NUM2, DP_DIVST, DP_DIVIT,
    DP_UPD, DP_WR_A, DP_WR_B, DP_MV_POS, DP_MV_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_A, ST_RD_B, ST_CAP_B, ST_DIFF, ST_SQX, ST_SQY, ST_SQR, ST_CMP,
    ST_DOTX, ST_DOTY, ST_DOTS, ST_DEN, ST_NUM1, ST_NUM2, ST_DIVST, ST_DIVIT,
    ST_UPD, ST_WR_A, ST_WR_B, ST_NEXT, ST_MV_RD, ST_MV_CAP, ST_MV_POS, ST_MV_OUT
  } state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] comp;   // 0 a.vx, 1 a.vy, 2 b.vx, 3 b.vy
    logic       hit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic collide;
    logic degenerate;
    logic out_free;
  } stat_t;

endpackage

// ===== src/puck_elastic_collision_step.sv =====
// Top level of the puck collision stepper: stream ports, APB registers,
// sequencer and datapath. Depends on pecs_pkg, pecs_ctrl, pecs_datapath.
//
// Input stream: tuser = opcode (0 load, 1 tick). A load writes one puck.
// A tick checks every pair i<j of the active pucks, then moves each puck
// and emits one result per puck, tlast on the final one. Each pair in
// contact, unless degenerate, gets four quotients from a restoring divider
// at one bit per cycle, for both velocity components of both pucks.
// One item is processed at a time; tready is high only between items.
// Results sit in an output register; a stalled receiver holds the move pass
// at the current puck, and the last result may wait while new items enter.
// Reset: store reads as pos 0, vel 0, radius 1, mass 16; registers return
// to 320, 240 and 5. No clearing pass is needed.
// Registers: 0 field_width, 1 field_height, 2 active_pucks at 4*i.
module puck_elastic_collision_step import pecs_pkg::*; #(
  parameter int MAX_PUCKS = MAX_PUCKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot[2:0], load_x[22:3], load_y[42:23], load_vx[58:43], load_vy[74:59],
  // load_radius[81:75], load_mass[89:82], zero fill
  input  logic [95:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // puck_index[2:0], new_x[22:3], new_y[42:23], new_vx[58:43], new_vy[74:59],
  // zero fill
  output logic [79:0] m_axis_tdata,
  // was_hit[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(MAX_PUCKS);

  logic [FLD_W-1:0] field_w_q, field_h_q;
  logic [ACT_W-1:0] active_q;
  cmd_t  cmd;
  stat_t stat;
  logic [IW-1:0] addr;
  puck_t load_rec;
  logic [2:0] out_index;
  logic [POS_W-1:0] out_x, out_y;
  logic [VEL_W-1:0] out_vx, out_vy;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_w_q <= FIELD_W_RST;
      field_h_q <= FIELD_H_RST;
      active_q  <= ACTIVE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_FIELD_W: field_w_q <= pwdata[FLD_W-1:0];
        REG_FIELD_H: field_h_q <= pwdata[FLD_W-1:0];
        REG_ACTIVE:  active_q  <= pwdata[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FIELD_W: prdata = 32'(field_w_q);
      REG_FIELD_H: prdata = 32'(field_h_q);
      REG_ACTIVE:  prdata = 32'(active_q);
      default:     prdata = '0;
    endcase
  end

  assign load_rec = '{x: s_axis_tdata[22:3], y: s_axis_tdata[42:23],
                      vx: s_axis_tdata[58:43], vy: s_axis_tdata[74:59],
                      rad: s_axis_tdata[81:75], mass: s_axis_tdata[89:82]};

  pecs_ctrl #(.MAX_PUCKS(MAX_PUCKS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_slot_i  (s_axis_tdata[2:0]),
    .active_i   (active_q),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .addr_o     (addr)
  );

  pecs_datapath #(.MAX_PUCKS(MAX_PUCKS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .load_i      (load_rec),
    .field_w_i   (field_w_q),
    .field_h_i   (field_h_q),
    .out_ready_i (m_axis_tready),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_index_o (out_index),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_vx_o    (out_vx),
    .out_vy_o    (out_vy),
    .out_hit_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_vy, out_vx, out_y, out_x, out_index};

endmodule

// ===== src/pecs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pecs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pecs_ctrl.sv =====
// Sequencer for the puck stepper: takes loads and ticks, walks pairs,
// collision steps, divider iterations and the move pass. Depends on pecs_pkg.
module pecs_ctrl import pecs_pkg::*; #(
  parameter int MAX_PUCKS = MAX_PUCKS_DEF,
  parameter int IW = $clog2(MAX_PUCKS),
  parameter int CW = $clog2(MAX_PUCKS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_op_i,
  input  logic [2:0]       in_slot_i,
  input  logic [ACT_W-1:0] active_i,
  input  stat_t            stat_i,
  output logic             in_ready_o,
  output cmd_t             cmd_o,
  output logic [IW-1:0]    addr_o
);

  state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, n_q, n_d, nn;
  logic [1:0] comp_q, comp_d;
  logic [4:0] cnt_q, cnt_d;
  logic [MAX_PUCKS-1:0] hit_q, hit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      n_q <= '0;
      comp_q <= '0;
      cnt_q <= '0;
      hit_q <= '0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
      n_q <= n_d;
      comp_q <= comp_d;
      cnt_q <= cnt_d;
      hit_q <= hit_d;
    end
  end

  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    n_d = n_q;
    comp_d = comp_q;
    cnt_d = cnt_q;
    hit_d = hit_q;
    in_ready_o = 1'b0;
    cmd_o = '{op: DP_NOP, comp: comp_q, hit: hit_q[k_q[IW-1:0]],
              last: ({1'b0, k_q} + 1'b1) == {1'b0, n_q}};
    addr_o = i_q[IW-1:0];
    if (32'(active_i) > MAX_PUCKS) begin
      nn = CW'(MAX_PUCKS);
    end else begin
      nn = CW'(active_i);
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        addr_o = IW'(in_slot_i);
        if (in_valid_i) begin
          if (!in_op_i) begin
            if (32'(in_slot_i) < MAX_PUCKS) begin
              cmd_o.op = DP_LOAD;
            end
          end else if (nn != '0) begin
            n_d = nn;
            hit_d = '0;
            i_d = '0;
            j_d = CW'(1);
            k_d = '0;
            state_d = (nn >= CW'(2)) ? ST_RD_A : ST_MV_RD;
          end
        end
      end
      ST_RD_A: state_d = ST_RD_B;
      ST_RD_B: begin
        addr_o = j_q[IW-1:0];
        cmd_o.op = DP_CAP_A;
        state_d = ST_CAP_B;
      end
      ST_CAP_B: begin
        cmd_o.op = DP_CAP_B;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.op = DP_DIFF;
        state_d = ST_SQX;
      end
      ST_SQX: begin
        cmd_o.op = DP_SQX;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.op = DP_SQY;
        state_d = ST_SQR;
      end
      ST_SQR: begin
        cmd_o.op = DP_SQR;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (!stat_i.collide) begin
          state_d = ST_NEXT;
        end else begin
          hit_d[i_q[IW-1:0]] = 1'b1;
          hit_d[j_q[IW-1:0]] = 1'b1;
          state_d = stat_i.degenerate ? ST_NEXT : ST_DOTX;
        end
      end
      ST_DOTX: begin
        cmd_o.op = DP_DOTX;
        state_d = ST_DOTY;
      end
      ST_DOTY: begin
        cmd_o.op = DP_DOTY;
        state_d = ST_DOTS;
      end
      ST_DOTS: begin
        cmd_o.op = DP_DOTS;
        state_d = ST_DEN;
      end
      ST_DEN: begin
        cmd_o.op = DP_DEN;
        comp_d = '0;
        state_d = ST_NUM1;
      end
      ST_NUM1: begin
        cmd_o.op = DP_NUM1;
        state_d = ST_NUM2;
      end
      ST_NUM2: begin
        cmd_o.op = DP_NUM2;
        state_d = ST_DIVST;
      end
      ST_DIVST: begin
        cmd_o.op = DP_DIVST;
        cnt_d = '0;
        state_d = ST_DIVIT;
      end
      ST_DIVIT: begin
        cmd_o.op = DP_DIVIT;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DIV_STEPS - 1)) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.op = DP_UPD;
        comp_d = comp_q + 2'd1;
        state_d = (comp_q == 2'd3) ? ST_WR_A : ST_NUM1;
      end
      ST_WR_A: begin
        cmd_o.op = DP_WR_A;
        state_d = ST_WR_B;
      end
      ST_WR_B: begin
        addr_o = j_q[IW-1:0];
        cmd_o.op = DP_WR_B;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (({1'b0, j_q} + 1'b1) < {1'b0, n_q}) begin
          j_d = j_q + 1'b1;
          state_d = ST_RD_A;
        end else if (({1'b0, i_q} + 2'd2) < {1'b0, n_q}) begin
          i_d = i_q + 1'b1;
          j_d = i_q + CW'(2);
          state_d = ST_RD_A;
        end else begin
          k_d = '0;
          state_d = ST_MV_RD;
        end
      end
      ST_MV_RD: begin
        addr_o = k_q[IW-1:0];
        state_d = ST_MV_CAP;
      end
      ST_MV_CAP: begin
        addr_o = k_q[IW-1:0];
        cmd_o.op = DP_CAP_A;
        state_d = ST_MV_POS;
      end
      ST_MV_POS: begin
        addr_o = k_q[IW-1:0];
        cmd_o.op = DP_MV_POS;
        state_d = ST_MV_OUT;
      end
      ST_MV_OUT: begin
        addr_o = k_q[IW-1:0];
        if (stat_i.out_free) begin
          cmd_o.op = DP_MV_OUT;
          if (({1'b0, k_q} + 1'b1) == {1'b0, n_q}) begin
            state_d = ST_IDLE;
          end else begin
            k_d = k_q + 1'b1;
            state_d = ST_MV_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/pecs_datapath.sv =====
// Datapath for the puck stepper: puck store, pair registers, shared
// multiplier, restoring divider, wall logic, output register.
// Depends on pecs_pkg and pecs_ram.
module pecs_datapath import pecs_pkg::*; #(
  parameter int MAX_PUCKS = MAX_PUCKS_DEF,
  parameter int IW = $clog2(MAX_PUCKS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [IW-1:0]     addr_i,
  input  puck_t             load_i,
  input  logic [FLD_W-1:0]  field_w_i,
  input  logic [FLD_W-1:0]  field_h_i,
  input  logic              out_ready_i,
  output stat_t             stat_o,
  output logic              out_valid_o,
  output logic [2:0]        out_index_o,
  output logic [POS_W-1:0]  out_x_o,
  output logic [POS_W-1:0]  out_y_o,
  output logic [VEL_W-1:0]  out_vx_o,
  output logic [VEL_W-1:0]  out_vy_o,
  output logic              out_hit_o,
  output logic              out_last_o
);

  function automatic logic [VEL_W-1:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) begin
      return 16'h7fff;
    end else if (v < -22'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic logic [POS_W-1:0] sat20(input logic signed [20:0] v);
    if (v > 21'sd524287) begin
      return 20'h7ffff;
    end else if (v < -21'sd524288) begin
      return 20'h80000;
    end
    return v[19:0];
  endfunction

  function automatic logic [VEL_W-1:0] make_pos(input logic [VEL_W-1:0] v);
    if (v[VEL_W-1]) begin
      return (v == 16'h8000) ? 16'h7fff : 16'(-v);
    end
    return v;
  endfunction

  function automatic logic [VEL_W-1:0] make_neg(input logic [VEL_W-1:0] v);
    if (!v[VEL_W-1] && v != '0) begin
      return 16'(-v);
    end
    return v;
  endfunction

  puck_t a_q, b_q, rec_rd, wrec, mv_rec;
  logic [MAX_PUCKS-1:0] valid_q;
  logic [IW-1:0] raddr_q;
  logic [PUCK_W-1:0] rdata;
  logic we;

  logic signed [20:0] dx_q, dy_q;
  logic signed [16:0] dvx_q, dvy_q;
  logic [15:0] rs_q;
  logic [8:0]  msum_q;
  logic [41:0] d2_q;
  logic signed [35:0] dot_q;
  logic [40:0] den_q;
  logic signed [67:0] prod_q;
  logic [62:0] rem_q;
  logic [59:0] dsh_q;
  logic [19:0] quo_q;
  logic neg_q;

  logic signed [45:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [67:0] mul_p;
  logic [MASS_W-1:0] coef_m;
  logic signed [20:0] q_s;
  logic [VEL_W-1:0] v_cur, v_new;
  logic [67:0] mag;

  logic signed [21:0] xs, ys, r22, fw22, fh22;
  logic [VEL_W-1:0] vx1, vy1;

  logic out_valid_q, out_hit_q, out_last_q;
  logic [2:0] out_index_q;
  puck_t out_q;

  pecs_ram #(.WIDTH(PUCK_W), .DEPTH(MAX_PUCKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_i),
    .wdata_i (wrec),
    .raddr_i (addr_i),
    .rdata_o (rdata)
  );

  assign rec_rd = valid_q[raddr_q] ? puck_t'(rdata) : PUCK_RST;

  // wall reflection on the moved puck in a_q
  always_comb begin
    xs   = $signed({{2{a_q.x[19]}}, a_q.x});
    ys   = $signed({{2{a_q.y[19]}}, a_q.y});
    r22  = $signed({7'b0, a_q.rad, 8'b0});
    fw22 = $signed({4'b0, field_w_i, 8'b0});
    fh22 = $signed({4'b0, field_h_i, 8'b0});
    vx1  = ((xs - r22) <= 22'sd0) ? make_pos(a_q.vx) : a_q.vx;
    vy1  = ((ys - r22) <= 22'sd0) ? make_pos(a_q.vy) : a_q.vy;
    mv_rec = a_q;
    mv_rec.vx = ((xs + r22) >= fw22) ? make_neg(vx1) : vx1;
    mv_rec.vy = ((ys + r22) >= fh22) ? make_neg(vy1) : vy1;
  end

  always_comb begin
    we = 1'b0;
    wrec = a_q;
    case (cmd_i.op)
      DP_LOAD: begin
        we = 1'b1;
        wrec = load_i;
      end
      DP_WR_A: we = 1'b1;
      DP_WR_B: begin
        we = 1'b1;
        wrec = b_q;
      end
      DP_MV_OUT: begin
        we = 1'b1;
        wrec = mv_rec;
      end
      default: ;
    endcase
  end

  always_comb begin
    coef_m = cmd_i.comp[1] ? a_q.mass : b_q.mass;
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      DP_SQX: begin
        mul_a = 46'(dx_q);
        mul_b = 22'(dx_q);
      end
      DP_SQY: begin
        mul_a = 46'(dy_q);
        mul_b = 22'(dy_q);
      end
      DP_SQR: begin
        mul_a = $signed(46'(rs_q));
        mul_b = $signed(22'(rs_q));
      end
      DP_DOTX: begin
        mul_a = 46'(dvx_q);
        mul_b = 22'(dx_q);
      end
      DP_DOTY: begin
        mul_a = 46'(dvy_q);
        mul_b = 22'(dy_q);
      end
      DP_DOTS: begin
        mul_a = $signed(46'(d2_q));
        mul_b = $signed(22'(msum_q));
      end
      DP_NUM1: begin
        mul_a = 46'(dot_q);
        mul_b = $signed(22'({coef_m, 1'b0}));
      end
      DP_NUM2: begin
        mul_a = prod_q[45:0];
        mul_b = cmd_i.comp[0] ? 22'(dy_q) : 22'(dx_q);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    mag = prod_q[67] ? 68'(-prod_q) : 68'(prod_q);
    q_s = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    case (cmd_i.comp)
      2'd0: v_cur = a_q.vx;
      2'd1: v_cur = a_q.vy;
      2'd2: v_cur = b_q.vx;
      default: v_cur = b_q.vy;
    endcase
    if (cmd_i.comp[1]) begin
      v_new = sat16(22'($signed(v_cur)) + 22'(q_s));
    end else begin
      v_new = sat16(22'($signed(v_cur)) - 22'(q_s));
    end
  end

  assign stat_o.collide    = d2_q < prod_q[41:0];
  assign stat_o.degenerate = (d2_q == '0) || (msum_q == '0);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (cmd_i.op == DP_MV_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= addr_i;
    case (cmd_i.op)
      DP_CAP_A: a_q <= rec_rd;
      DP_CAP_B: b_q <= rec_rd;
      DP_DIFF: begin
        dx_q <= $signed({b_q.x[19], b_q.x}) - $signed({a_q.x[19], a_q.x});
        dy_q <= $signed({b_q.y[19], b_q.y}) - $signed({a_q.y[19], a_q.y});
        dvx_q <= $signed({a_q.vx[15], a_q.vx}) - $signed({b_q.vx[15], b_q.vx});
        dvy_q <= $signed({a_q.vy[15], a_q.vy}) - $signed({b_q.vy[15], b_q.vy});
        rs_q <= {8'({1'b0, a_q.rad} + {1'b0, b_q.rad}), 8'b0};
        msum_q <= {1'b0, a_q.mass} + {1'b0, b_q.mass};
      end
      DP_SQX, DP_DOTX, DP_NUM1, DP_NUM2: prod_q <= mul_p;
      DP_SQY: begin
        d2_q <= prod_q[41:0];
        prod_q <= mul_p;
      end
      DP_SQR: begin
        d2_q <= d2_q + prod_q[41:0];
        prod_q <= mul_p;
      end
      DP_DOTY: begin
        dot_q <= prod_q[35:0];
        prod_q <= mul_p;
      end
      DP_DOTS: begin
        dot_q <= dot_q + prod_q[35:0];
        prod_q <= mul_p;
      end
      DP_DEN: den_q <= prod_q[40:0];
      DP_DIVST: begin
        neg_q <= prod_q[67];
        rem_q <= mag[62:0] + 63'(den_q >> 1);
        dsh_q <= 60'(den_q) << (DIV_STEPS - 1);
        quo_q <= '0;
      end
      DP_DIVIT: begin
        if (rem_q >= 63'(dsh_q)) begin
          rem_q <= rem_q - 63'(dsh_q);
          quo_q <= {quo_q[18:0], 1'b1};
        end else begin
          quo_q <= {quo_q[18:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      DP_UPD: begin
        case (cmd_i.comp)
          2'd0: a_q.vx <= v_new;
          2'd1: a_q.vy <= v_new;
          2'd2: b_q.vx <= v_new;
          default: b_q.vy <= v_new;
        endcase
      end
      DP_MV_POS: begin
        a_q.x <= sat20($signed({a_q.x[19], a_q.x}) + 21'($signed(a_q.vx)));
        a_q.y <= sat20($signed({a_q.y[19], a_q.y}) + 21'($signed(a_q.vy)));
      end
      DP_MV_OUT: begin
        out_q <= mv_rec;
        out_index_q <= 3'(addr_i);
        out_hit_q <= cmd_i.hit;
        out_last_q <= cmd_i.last;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_x_o     = out_q.x;
  assign out_y_o     = out_q.y;
  assign out_vx_o    = out_q.vx;
  assign out_vy_o    = out_q.vy;
  assign out_hit_o   = out_hit_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== src/pecs_checker.sv =====
// Port-level checks for the puck collision stepper, bound to the top level.
// Depends on puck_elastic_collision_step.
module pecs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("load left the block busy");

  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("idle with a non-final result pending");

  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
    else $error("tlast changed while stalled");

endmodule

bind puck_elastic_collision_step pecs_checker u_pecs_checker (.*);
